@@ rtl/fqd_pkg.sv @@
// ----------------------------------------------------------------------------
// fqd_pkg
// Types, sizes and codes shared by the handle queue with delete by key.
// ----------------------------------------------------------------------------
package fqd_pkg;

  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned HANDLE_BITS = 16;

  // Slot index and occupancy widths (count must also hold QUEUE_DEPTH itself).
  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_PUSH   = 2'd1,
    OP_POP    = 2'd2,
    OP_DELETE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    opcode_e                opcode;
    logic [HANDLE_BITS-1:0] handle;
  } req_t;

  typedef struct packed {
    status_e                status;
    logic [HANDLE_BITS-1:0] popped_handle;
    logic [HANDLE_BITS-1:0] head_handle;
    logic [CNT_W-1:0]       entry_count;
    logic                   is_empty;
  } rsp_t;

  // Broadcast from the top level to every cell of the row.
  typedef struct packed {
    logic                   push;
    logic                   pop;
    logic                   del;
    logic [HANDLE_BITS-1:0] handle;
    logic [CNT_W-1:0]       count;
  } cell_ctrl_t;

endpackage

@@ rtl/fqd_cell.sv @@
// ----------------------------------------------------------------------------
// fqd_cell
// One queue slot: holds a handle, compares it with the delete key, and takes
// its right-hand neighbour's handle when the row shifts forward.
// ----------------------------------------------------------------------------
module fqd_cell
  import fqd_pkg::*;
(
  input  logic                   clk_i,
  input  logic [IDX_W-1:0]       idx_i,
  input  cell_ctrl_t             ctrl_i,
  input  logic [HANDLE_BITS-1:0] next_handle_i,
  input  logic                   found_i,
  output logic                   found_o,
  output logic [HANDLE_BITS-1:0] handle_q_o,
  output logic [HANDLE_BITS-1:0] handle_d_o
);

  logic [HANDLE_BITS-1:0] handle_q, handle_d;
  logic                   occupied;
  logic                   push_here;
  logic                   match;
  logic                   shift;

  assign occupied  = {{(CNT_W-IDX_W){1'b0}}, idx_i} < ctrl_i.count;
  assign push_here = ctrl_i.push && ({{(CNT_W-IDX_W){1'b0}}, idx_i} == ctrl_i.count);
  assign match     = ctrl_i.del && occupied && (handle_q == ctrl_i.handle);
  assign found_o   = found_i || match;
  // Pop moves the whole row; delete moves the matching slot and all after it.
  assign shift     = ctrl_i.pop || (ctrl_i.del && found_o);

  always_comb begin
    handle_d = handle_q;
    if (push_here) begin
      handle_d = ctrl_i.handle;
    end else if (shift) begin
      handle_d = next_handle_i;
    end
  end

  always_ff @(posedge clk_i) begin
    handle_q <= handle_d;
  end

  assign handle_q_o = handle_q;
  assign handle_d_o = handle_d;

endmodule

@@ rtl/fifo_queue_with_delete_by_key_top.sv @@
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_by_key_top
// First-in first-out queue of process handles with removal of the oldest
// entry matching a key, built as a row of shifting cells.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                     payload
//   request   in         start high, busy low          req_i  (req_t)
//   result    out        result_valid_o for one cycle  rsp_o  (rsp_t)
//
// Cycles: a transaction is accepted on any edge with start high; busy stays
// low, so one transaction per cycle is taken. Its result appears on rsp_o
// for exactly one cycle, in the cycle after acceptance.
// The cost of a cycle is set by the delete key compare in every slot and the
// found chain that runs along the row of cells.
// Reset: rst_ni clears the occupancy and the result strobe; slot contents
// are left undefined and are never shown before being written.
// Stalls: the receiver cannot hold results off, so no stall path exists.
// ----------------------------------------------------------------------------
module fifo_queue_with_delete_by_key_top
  import fqd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic result_valid_o,
  output rsp_t rsp_o
);

  logic                   accept;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   full, empty;
  cell_ctrl_t             ctrl;
  logic [QUEUE_DEPTH:0]   found_chain;
  logic [HANDLE_BITS-1:0] cell_q [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] cell_d [QUEUE_DEPTH];
  logic                   found;
  rsp_t                   rsp_q, rsp_d;
  logic                   valid_q;

  // Every transaction finishes in its accept cycle, so the port never blocks.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_q == '0);

  // Operation decode; failing operations are squashed here so cells stay put.
  always_comb begin
    ctrl.push   = accept && (req_i.opcode == OP_PUSH)   && !full;
    ctrl.pop    = accept && (req_i.opcode == OP_POP)    && !empty;
    ctrl.del    = accept && (req_i.opcode == OP_DELETE) && !empty;
    ctrl.handle = req_i.handle;
    ctrl.count  = count_q;
  end

  // Row of cells; slot 0 is the oldest. The found flag ripples tailwards so
  // only the first match and its successors shift.
  assign found_chain[0] = 1'b0;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [HANDLE_BITS-1:0] next_handle;
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign next_handle = cell_q[g];
    end else begin : g_mid
      assign next_handle = cell_q[g+1];
    end

    fqd_cell u_cell (
      .clk_i         (clk_i),
      .idx_i         (IDX_W'(g)),
      .ctrl_i        (ctrl),
      .next_handle_i (next_handle),
      .found_i       (found_chain[g]),
      .found_o       (found_chain[g+1]),
      .handle_q_o    (cell_q[g]),
      .handle_d_o    (cell_d[g])
    );
  end

  assign found = found_chain[QUEUE_DEPTH];

  always_comb begin
    count_d = count_q;
    if (ctrl.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.pop || (ctrl.del && found)) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Result assembly, taken from the state as it will be after this edge.
  always_comb begin
    rsp_d.status = ST_OK;
    case (req_i.opcode)
      OP_PUSH: begin
        if (full) rsp_d.status = ST_FULL;
      end
      OP_POP: begin
        if (empty) rsp_d.status = ST_EMPTY;
      end
      OP_DELETE: begin
        if (empty) begin
          rsp_d.status = ST_EMPTY;
        end else if (!found) begin
          rsp_d.status = ST_NOT_FOUND;
        end
      end
      default: begin
        rsp_d.status = ST_OK;
      end
    endcase
    rsp_d.popped_handle = ctrl.pop ? cell_q[0] : '0;
    rsp_d.head_handle   = (count_d != '0) ? cell_d[0] : '0;
    rsp_d.entry_count   = count_d;
    rsp_d.is_empty      = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

endmodule

@@ rtl/fqd_checker.sv @@
// ----------------------------------------------------------------------------
// fqd_checker
// Port-level checks on the handle queue, bound to the top level.
// ----------------------------------------------------------------------------
module fqd_checker
  import fqd_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic result_valid_o,
  input rsp_t rsp_o
);

  // Each accepted transaction gives its result in the following cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> result_valid_o)
    else $error("accepted transaction gave no result");

  // No result without a transaction accepted the cycle before.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy))
    else $error("result without transaction");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (rsp_o.is_empty == (rsp_o.entry_count == '0)) &&
                       (rsp_o.entry_count <= CNT_W'(QUEUE_DEPTH)))
    else $error("count and empty flag disagree");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && rsp_o.is_empty) |-> (rsp_o.head_handle == '0))
    else $error("empty queue shows a head handle");

  a_popped_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (rsp_o.popped_handle != '0)) |-> (rsp_o.status == ST_OK))
    else $error("popped handle on failed transaction");

endmodule

bind fifo_queue_with_delete_by_key_top fqd_checker u_fqd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .req_i          (req_i),
  .result_valid_o (result_valid_o),
  .rsp_o          (rsp_o)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the handle queue with delete by key. A mirror of
// the queue predicts every result from the accepted requests; a directed
// opening pass is followed by random traffic that leans towards filling,
// draining or holding the queue.
// ----------------------------------------------------------------------------
module tb;
  import fqd_pkg::*;

  // --------------------------------------------------------------------------
  // Queue mirror: own copy of the slots and fill level, plus the results
  // still owed by the block, oldest first.
  // --------------------------------------------------------------------------
  class handle_queue_mirror;
    logic [HANDLE_BITS-1:0] slots [QUEUE_DEPTH];
    int unsigned            fill;
    rsp_t                   due_rsps [$];
    int unsigned            errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // Drop slot pos; everything behind it moves up one place.
    function void close_gap(int unsigned pos);
      for (int unsigned i = pos; i + 1 < fill; i++) slots[i] = slots[i+1];
      fill--;
    endfunction

    // Apply one accepted transaction and queue the result it must give.
    function void take_request(req_t r);
      rsp_t want;
      bit   hit;
      want        = '0;
      want.status = ST_OK;
      hit         = 1'b0;
      case (r.opcode)
        OP_PUSH: begin
          if (fill >= QUEUE_DEPTH) begin
            want.status = ST_FULL;
          end else begin
            slots[fill] = r.handle;
            fill++;
          end
        end
        OP_POP: begin
          if (fill == 0) begin
            want.status = ST_EMPTY;
          end else begin
            want.popped_handle = slots[0];
            close_gap(0);
          end
        end
        OP_DELETE: begin
          if (fill == 0) begin
            want.status = ST_EMPTY;
          end else begin
            // oldest match only
            for (int unsigned i = 0; i < fill && !hit; i++) begin
              if (slots[i] == r.handle) begin
                close_gap(i);
                hit = 1'b1;
              end
            end
            want.status = hit ? ST_OK : ST_NOT_FOUND;
          end
        end
        default: ;
      endcase
      want.head_handle = (fill != 0) ? slots[0] : '0;
      want.entry_count = CNT_W'(fill);
      want.is_empty    = (fill == 0);
      due_rsps.push_back(want);
    endfunction

    // Compare one result with the oldest outstanding expectation.
    function void match_result(rsp_t got);
      rsp_t want;
      if (due_rsps.size() == 0) begin
        $error("result with no transaction outstanding: %p", got);
        errors++;
        return;
      end
      want = due_rsps.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.popped_handle !== want.popped_handle) begin
        $error("popped_handle: expected %h, got %h", want.popped_handle,
               got.popped_handle);
        errors++;
      end
      if (got.head_handle !== want.head_handle) begin
        $error("head_handle: expected %h, got %h", want.head_handle,
               got.head_handle);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count,
               got.entry_count);
        errors++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block and its hookup
  // --------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic result_valid_o;
  rsp_t rsp_o;

  handle_queue_mirror mirror = new();

  // When set, transactions go back to back with no idle cycles between them.
  bit calm;

  fifo_queue_with_delete_by_key_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Results live for one cycle only and cannot be held off, so every edge
  // with the strobe up is a result to check. Values sampled here are the
  // ones settled before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) mirror.match_result(rsp_o);
  end

  // Idle length after a transaction: mostly none or short, now and then
  // long, so gaps land on every phase of the result pipeline.
  function automatic int unsigned idle_cycles();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Handles come mostly from a small pool so that deletes hit and
  // duplicates occur; the rest are full-width random.
  function automatic logic [HANDLE_BITS-1:0] pick_handle();
    logic [HANDLE_BITS-1:0] pool [8];
    pool[0] = '0;
    pool[1] = '1;
    pool[2] = HANDLE_BITS'(1);
    pool[3] = {1'b1, {(HANDLE_BITS-1){1'b0}}};
    pool[4] = HANDLE_BITS'('h1234);
    pool[5] = HANDLE_BITS'('h1235);
    pool[6] = {(HANDLE_BITS/2){2'b10}};
    pool[7] = {(HANDLE_BITS/2){2'b01}};
    if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, 7)];
    return HANDLE_BITS'($urandom);
  endfunction

  // Offer one transaction and hold it until taken (start high, busy low at
  // the edge), then note it in the mirror and idle for a while if drawn.
  task automatic issue(input opcode_e op, input logic [HANDLE_BITS-1:0] h);
    req_t        r;
    int unsigned gap;
    r.opcode = op;
    r.handle = h;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    mirror.take_request(r);
    gap = idle_cycles();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned p_push;
    int unsigned p_pop;
    int unsigned p_del;
    int unsigned roll;
    opcode_e     op;

    start  <= 1'b0;
    req_i  <= '0;
    rst_ni <= 1'b0;
    calm   = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-queue cases, handle zero as a real entry, fill to the
    // brim, push when full, delete misses, delete of the first of two
    // duplicates, of the tail and of the head, then drain past empty.
    issue(OP_QUERY,  '0);
    issue(OP_POP,    '0);
    issue(OP_DELETE, 16'h1234);
    issue(OP_PUSH,   16'h0000);
    issue(OP_QUERY,  16'h0000);
    issue(OP_PUSH,   16'hffff);
    issue(OP_PUSH,   16'haaaa);
    issue(OP_PUSH,   16'h5555);
    issue(OP_PUSH,   16'haaaa);
    issue(OP_PUSH,   16'h0001);
    issue(OP_PUSH,   16'h8000);
    issue(OP_PUSH,   16'h7fff);
    issue(OP_PUSH,   16'h1111);
    issue(OP_DELETE, 16'h4321);
    issue(OP_DELETE, 16'haaaa);
    issue(OP_DELETE, 16'h7fff);
    issue(OP_DELETE, 16'h0000);
    issue(OP_POP,    16'hffff);
    issue(OP_POP,    16'h0000);
    issue(OP_PUSH,   16'h2222);
    issue(OP_QUERY,  16'hffff);
    repeat (4) issue(OP_POP, 16'h5a5a);
    issue(OP_POP,    '0);
    issue(OP_DELETE, 16'h0000);

    // Random: runs of 30 transactions, each leaning towards fill, drain or
    // a steady level, so full and empty are both reached often.
    repeat (15) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0:       begin p_push = 65; p_pop = 10; p_del = 15; end
        1:       begin p_push = 15; p_pop = 40; p_del = 35; end
        default: begin p_push = 40; p_pop = 25; p_del = 25; end
      endcase
      repeat (30) begin
        roll = $urandom_range(0, 99);
        if (roll < p_push)                      op = OP_PUSH;
        else if (roll < p_push + p_pop)         op = OP_POP;
        else if (roll < p_push + p_pop + p_del) op = OP_DELETE;
        else                                    op = OP_QUERY;
        issue(op, pick_handle());
      end
    end

    // Drain: wait for every outstanding result, then watch on in case a stray
    // strobe follows.
    start <= 1'b0;
    while (mirror.due_rsps.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    if (mirror.errors == 0 && mirror.due_rsps.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
